// ===== hdl/c2ll_pkg.sv =====
package c2ll_pkg;

    // Port field width and internal working widths
    localparam int FIELD_W = 32;
    localparam int WORK_W  = 64;
    localparam int TURN_W  = 64;

    // floor(2^64 / (2 pi))
    localparam logic [TURN_W-1:0] INV_TWO_PI = 64'h28BE_60DB_9391_054A;

    typedef struct packed {
        logic signed [FIELD_W-1:0] x_coord;
        logic signed [FIELD_W-1:0] y_coord;
        logic signed [FIELD_W-1:0] z_coord;
    } t_in_item;

    typedef struct packed {
        logic        [FIELD_W-1:0] longitude;
        logic signed [FIELD_W-1:0] latitude;
    } t_out_item;

    // 2^(64 - i*n), or zero once the exponent runs out
    function automatic logic [TURN_W-1:0] pow_term(input int i, input int n);
        int e;
        e = i * n;
        if (e >= TURN_W) begin
            return '0;
        end
        return 64'd1 << (TURN_W - e);
    endfunction

    // atan(2^-i) as a fraction of a turn, 2^64 to the turn.
    // Truncated Taylor series in radians, then scaled by 1/(2 pi).
    function automatic logic [TURN_W-1:0] atan_entry(input int i);
        logic [TURN_W-1:0]   sum;
        logic [2*TURN_W-1:0] prod;
        if (i == 0) begin
            return 64'd1 << 61;
        end
        sum = pow_term(i, 1);
        sum = sum - pow_term(i, 3) / 64'd3;
        sum = sum + pow_term(i, 5) / 64'd5;
        sum = sum - pow_term(i, 7) / 64'd7;
        sum = sum + pow_term(i, 9) / 64'd9;
        sum = sum - pow_term(i, 11) / 64'd11;
        sum = sum + pow_term(i, 13) / 64'd13;
        sum = sum - pow_term(i, 15) / 64'd15;
        sum = sum + pow_term(i, 17) / 64'd17;
        sum = sum - pow_term(i, 19) / 64'd19;
        sum = sum + pow_term(i, 21) / 64'd21;
        sum = sum - pow_term(i, 23) / 64'd23;
        sum = sum + pow_term(i, 25) / 64'd25;
        sum = sum - pow_term(i, 27) / 64'd27;
        sum = sum + pow_term(i, 29) / 64'd29;
        sum = sum - pow_term(i, 31) / 64'd31;
        sum = sum + pow_term(i, 33) / 64'd33;
        sum = sum - pow_term(i, 35) / 64'd35;
        sum = sum + pow_term(i, 37) / 64'd37;
        sum = sum - pow_term(i, 39) / 64'd39;
        sum = sum + pow_term(i, 41) / 64'd41;
        sum = sum - pow_term(i, 43) / 64'd43;
        sum = sum + pow_term(i, 45) / 64'd45;
        sum = sum - pow_term(i, 47) / 64'd47;
        sum = sum + pow_term(i, 49) / 64'd49;
        sum = sum - pow_term(i, 51) / 64'd51;
        sum = sum + pow_term(i, 53) / 64'd53;
        sum = sum - pow_term(i, 55) / 64'd55;
        sum = sum + pow_term(i, 57) / 64'd57;
        sum = sum - pow_term(i, 59) / 64'd59;
        sum = sum + pow_term(i, 61) / 64'd61;
        sum = sum - pow_term(i, 63) / 64'd63;
        prod = {{TURN_W{1'b0}}, sum} * {{TURN_W{1'b0}}, INV_TWO_PI};
        return prod[2*TURN_W-1:TURN_W];
    endfunction

endpackage

// ===== hdl/c2ll_vector.sv =====
module c2ll_vector #(
    parameter int STAGES = 32,
    parameter int SIDE_W = 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [c2ll_pkg::WORK_W-1:0]  i_x,
    input  logic signed [c2ll_pkg::WORK_W-1:0]  i_y,
    input  logic        [c2ll_pkg::TURN_W-1:0]  i_ang,
    input  logic        [SIDE_W-1:0]            i_side,
    output logic                                o_valid,
    output logic signed [c2ll_pkg::WORK_W-1:0]  o_x,
    output logic        [c2ll_pkg::TURN_W-1:0]  o_ang,
    output logic        [SIDE_W-1:0]            o_side
);

    localparam int W = c2ll_pkg::WORK_W;
    localparam int A = c2ll_pkg::TURN_W;

    logic        [STAGES-1:0] r_valid;
    logic signed [W-1:0]      r_x    [STAGES];
    logic signed [W-1:0]      r_y    [STAGES];
    logic        [A-1:0]      r_ang  [STAGES];
    logic        [SIDE_W-1:0] r_side [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        localparam logic [A-1:0] ATAN = c2ll_pkg::atan_entry(s);

        logic                v_in;
        logic signed [W-1:0] x_in;
        logic signed [W-1:0] y_in;
        logic        [A-1:0] ang_in;
        logic   [SIDE_W-1:0] side_in;
        logic signed [W-1:0] n_x;
        logic signed [W-1:0] n_y;
        logic        [A-1:0] n_ang;

        if (s == 0) begin : g_first
            assign v_in    = i_valid;
            assign x_in    = i_x;
            assign y_in    = i_y;
            assign ang_in  = i_ang;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_valid[s-1];
            assign x_in    = r_x[s-1];
            assign y_in    = r_y[s-1];
            assign ang_in  = r_ang[s-1];
            assign side_in = r_side[s-1];
        end

        // Turn clockwise while y is non-negative, else counterclockwise
        always_comb begin
            if (!y_in[W-1]) begin
                n_x   = x_in + (y_in >>> s);
                n_y   = y_in - (x_in >>> s);
                n_ang = ang_in + ATAN;
            end else begin
                n_x   = x_in - (y_in >>> s);
                n_y   = y_in + (x_in >>> s);
                n_ang = ang_in - ATAN;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[s]    <= n_x;
                r_y[s]    <= n_y;
                r_ang[s]  <= n_ang;
                r_side[s] <= side_in;
            end
        end
    end

    assign o_valid = r_valid[STAGES-1];
    assign o_x     = r_x[STAGES-1];
    assign o_ang   = r_ang[STAGES-1];
    assign o_side  = r_side[STAGES-1];

endmodule

// ===== hdl/cartesian_to_lon_lat.sv =====
// Channel   Valid     Stall     Payload   Direction
// input     i_valid   o_stall   i_item    x, y, z coordinates in
// output    o_valid   i_stall   o_item    longitude, latitude out
//
// One transaction per cycle while not stalled; stages in order: input register,
// planar CORDIC run, elevation CORDIC run, output register.
// Reset clears the valid bits only; no clearing pass.
// A stalled result freezes the whole pipeline; o_stall follows the held output.
module cartesian_to_lon_lat #(
    parameter int COORD_WIDTH   = 32,
    parameter int ANGLE_WIDTH   = 32,
    parameter int CORDIC_STAGES = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  c2ll_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output c2ll_pkg::t_out_item  o_item
);

    localparam int W        = c2ll_pkg::WORK_W;
    localparam int A        = c2ll_pkg::TURN_W;
    localparam int FW       = c2ll_pkg::FIELD_W;
    localparam int SCALE_SH = 60 - COORD_WIDTH;
    localparam int DROP     = A - ANGLE_WIDTH;
    localparam int LAT_SIDE = ANGLE_WIDTH + 2;

    localparam logic [A-1:0]           HALF      = A'(1) << (DROP - 1);
    localparam logic [A-1:0]           HALF_TURN = A'(1) << (A - 1);
    localparam logic [ANGLE_WIDTH-1:0] QUARTER   = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);

    logic en;

    // input register
    logic signed [COORD_WIDTH-1:0] x_c, y_c, z_c;
    logic signed [W-1:0]           x_s, y_s, z_s;
    logic                          r_in_valid;
    logic signed [W-1:0]           r_x0, r_y0, r_zk0;
    logic        [A-1:0]           r_ang0;
    logic                          r_xy_zero0, r_z_neg0, r_z_nz0;

    // planar and gain runs
    logic                v1;
    logic signed [W-1:0] x1, zk1;
    logic        [A-1:0] ang1;
    logic                xy_zero1;
    logic          [1:0] zflags1;

    logic        [A-1:0]           lon_sum;
    logic        [ANGLE_WIDTH-1:0] lon_q;
    logic signed [W-1:0]           r_mag;

    // elevation run
    logic                v2;
    logic        [A-1:0] ang2;
    logic [LAT_SIDE-1:0] side2;

    logic        [A-1:0]           lat_pos, lat_sum;
    logic        [ANGLE_WIDTH-1:0] lat_mag, lat_lim, lat_q;
    c2ll_pkg::t_out_item           n_out;
    logic                          r_out_valid;
    c2ll_pkg::t_out_item           r_out;

    // advance everything unless the held result is being stalled
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    always_comb begin
        x_c = COORD_WIDTH'(i_item.x_coord);
        y_c = COORD_WIDTH'(i_item.y_coord);
        z_c = COORD_WIDTH'(i_item.z_coord);
        x_s = W'(x_c) <<< SCALE_SH;
        y_s = W'(y_c) <<< SCALE_SH;
        z_s = W'(z_c) <<< SCALE_SH;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_valid;
        end
    end

    // fold the left half-plane onto the right, starting from a half turn
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x0       <= x_c[COORD_WIDTH-1] ? -x_s : x_s;
            r_y0       <= x_c[COORD_WIDTH-1] ? -y_s : y_s;
            r_ang0     <= x_c[COORD_WIDTH-1] ? HALF_TURN : '0;
            r_zk0      <= z_c[COORD_WIDTH-1] ? -z_s : z_s;
            r_xy_zero0 <= (x_c == '0) && (y_c == '0);
            r_z_neg0   <= z_c[COORD_WIDTH-1];
            r_z_nz0    <= (z_c != '0);
        end
    end

    c2ll_vector #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (1)
    ) u_planar (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_in_valid),
        .i_x     (r_x0),
        .i_y     (r_y0),
        .i_ang   (r_ang0),
        .i_side  (r_xy_zero0),
        .o_valid (v1),
        .o_x     (x1),
        .o_ang   (ang1),
        .o_side  (xy_zero1)
    );

    // give |z| the same CORDIC gain as the planar magnitude
    c2ll_vector #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (2)
    ) u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_in_valid),
        .i_x     (r_zk0),
        .i_y     ('0),
        .i_ang   ('0),
        .i_side  ({r_z_neg0, r_z_nz0}),
        .o_valid (),
        .o_x     (zk1),
        .o_ang   (),
        .o_side  (zflags1)
    );

    always_comb begin
        lon_sum = ang1 + HALF;
        lon_q   = xy_zero1 ? '0 : lon_sum[A-1:DROP];
        r_mag   = xy_zero1 ? '0 : x1;
    end

    c2ll_vector #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (LAT_SIDE)
    ) u_elev (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v1),
        .i_x     (r_mag),
        .i_y     (zk1),
        .i_ang   ('0),
        .i_side  ({lon_q, zflags1}),
        .o_valid (v2),
        .o_x     (),
        .o_ang   (ang2),
        .o_side  (side2)
    );

    // drop a tiny negative residue, round, limit to a quarter turn, apply sign of z
    always_comb begin
        lat_pos = ang2[A-1] ? '0 : ang2;
        lat_sum = lat_pos + HALF;
        lat_mag = lat_sum[A-1:DROP];
        lat_lim = (lat_mag > QUARTER) ? QUARTER : lat_mag;
        lat_q   = side2[1] ? (ANGLE_WIDTH'(0) - lat_lim) : lat_lim;
        if (!side2[0]) begin
            lat_q = '0;
        end
        n_out.longitude = FW'(side2[LAT_SIDE-1:2]);
        n_out.latitude  = FW'(lat_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule
